FILE: rtl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and codes of the I2C master bit engine: commands, status codes,
// register indexes, sequencer phases and the packed stream words.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    localparam int CfgWidth   = 16;
    localparam int CfgIdxWidth = 2;
    localparam int WordWidth  = 16;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;
    localparam logic [2:0] CMD_RECOVER = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_NACK    = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    localparam logic [CfgIdxWidth-1:0] REG_BIT_DELAY       = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_STRETCH_TIMEOUT = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_SIMULATE_LINES  = 2'd2;

    localparam logic [CfgWidth-1:0] BIT_DELAY_RESET       = 16'd10;
    localparam logic [CfgWidth-1:0] STRETCH_TIMEOUT_RESET = 16'd1000;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [3:0] DATA_BITS = 4'd8;

    typedef enum logic [18:0] {
        PH_IDLE      = 19'h00001,
        PH_S_SDA_REL = 19'h00002,
        PH_S_SCL_REL = 19'h00004,
        PH_S_POLL    = 19'h00008,
        PH_S_SDA_LOW = 19'h00010,
        PH_S_SCL_LOW = 19'h00020,
        PH_P_SDA_LOW = 19'h00040,
        PH_P_SCL_REL = 19'h00080,
        PH_P_POLL    = 19'h00100,
        PH_P_SDA_REL = 19'h00200,
        PH_B_SDA     = 19'h00400,
        PH_B_SCL_REL = 19'h00800,
        PH_B_POLL    = 19'h01000,
        PH_B_SCL_LOW = 19'h02000,
        PH_R_SDA_REL = 19'h04000,
        PH_R_CHECK   = 19'h08000,
        PH_R_SCL_REL = 19'h10000,
        PH_R_POLL    = 19'h20000,
        PH_FINISH    = 19'h40000
    } t_phase;

    typedef struct packed {
        logic [CfgWidth-1:0] bit_delay;
        logic [CfgWidth-1:0] stretch_timeout;
        logic                simulate_lines;
    } t_cfg;

    typedef struct packed {
        logic [1:0] pad;
        logic       sda_level;
        logic       scl_level;
        logic       reply_ack;
        logic [7:0] data_byte;
        logic [2:0] command;
    } t_in_word;

    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] read_data;
        logic [1:0] status;
        logic       command_done;
        logic       engine_busy;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } t_out_word;

endpackage

FILE: rtl/i2cbe_step.sv
// ----------------------------------------------------------------------------
// i2cbe_step
// Bit sequencer state and its one-tick update: command launch, line actions,
// bit delay, SCL polling with stretch timeout, byte shifting and recovery.
// ----------------------------------------------------------------------------
module i2cbe_step #(
    parameter int COUNT_WIDTH     = 16,
    parameter int RECOVERY_PULSES = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  i2cbe_pkg::t_cfg     i_cfg,
    input  i2cbe_pkg::t_in_word i_word,
    output i2cbe_pkg::t_out_word o_word
);
    import i2cbe_pkg::*;

    localparam logic [3:0] PulseLimit = 4'(RECOVERY_PULSES);

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_active_cmd, n_active_cmd;
    logic [3:0]             r_bit_count, n_bit_count;
    logic [7:0]             r_shift, n_shift;
    logic                   r_ack, n_ack;
    logic [COUNT_WIDTH-1:0] r_delay, n_delay;
    logic [COUNT_WIDTH-1:0] r_wait, n_wait;
    logic [3:0]             r_pulse, n_pulse;
    logic                   r_scl_drive, n_scl_drive;
    logic                   r_sda_drive, n_sda_drive;
    logic [7:0]             r_last_read, n_last_read;

    logic [COUNT_WIDTH-1:0] delay_sat;
    logic [COUNT_WIDTH-1:0] limit_sat;
    logic [COUNT_WIDTH-1:0] wait_inc;
    logic                   sim, scl_h, sda_h;
    logic                   pre_to, poll_high, poll_to;
    logic [COUNT_WIDTH-1:0] wait_after;
    logic                   done;
    logic [1:0]             status;

    generate
        if (COUNT_WIDTH >= CfgWidth) begin : g_wide
            assign delay_sat = COUNT_WIDTH'(i_cfg.bit_delay);
            assign limit_sat = COUNT_WIDTH'(i_cfg.stretch_timeout);
        end else begin : g_narrow
            assign delay_sat = (|i_cfg.bit_delay[CfgWidth-1:COUNT_WIDTH]) ? '1 :
                               i_cfg.bit_delay[COUNT_WIDTH-1:0];
            assign limit_sat = (|i_cfg.stretch_timeout[CfgWidth-1:COUNT_WIDTH]) ? '1 :
                               i_cfg.stretch_timeout[COUNT_WIDTH-1:0];
        end
    endgenerate

    assign sim   = i_cfg.simulate_lines;
    assign scl_h = sim | i_word.scl_level;
    assign sda_h = sim | i_word.sda_level;

    // poll of SCL; the wait count only matters in poll phases, where it counts up while SCL is low
    assign wait_inc   = (r_wait != '1) ? r_wait + 1'b1 : r_wait;
    assign pre_to     = (r_wait >= limit_sat);
    assign poll_high  = !pre_to && scl_h;
    assign poll_to    = pre_to || (!scl_h && (wait_inc >= limit_sat));
    assign wait_after = (pre_to || scl_h) ? r_wait : wait_inc;

    always_comb begin
        logic skip;
        skip         = 1'b0;
        n_phase      = r_phase;
        n_active_cmd = r_active_cmd;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_ack        = r_ack;
        n_delay      = r_delay;
        n_wait       = r_wait;
        n_pulse      = r_pulse;
        n_scl_drive  = r_scl_drive;
        n_sda_drive  = r_sda_drive;
        n_last_read  = r_last_read;
        done         = 1'b0;
        status       = ST_OK;

        if (r_phase == PH_IDLE) begin
            if (i_word.command inside {[CMD_START:CMD_RECOVER]}) begin
                n_active_cmd = i_word.command;
                n_bit_count  = '0;
                n_wait       = '0;
                n_pulse      = '0;
                n_shift      = i_word.data_byte;
                n_ack        = 1'b0;
                if (i_word.command == CMD_READ) begin
                    n_shift = '0;
                    n_ack   = i_word.reply_ack;
                end
                case (i_word.command)
                    CMD_START, CMD_RESTART: n_phase = PH_S_SDA_REL;
                    CMD_STOP:               n_phase = PH_P_SDA_LOW;
                    CMD_RECOVER:            n_phase = PH_R_SDA_REL;
                    default:                n_phase = PH_B_SDA;
                endcase
            end
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
            skip    = 1'b1;
        end

        if (!skip) begin
            case (n_phase)
                PH_S_SDA_REL: begin
                    n_sda_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_S_SCL_REL;
                end
                PH_S_SCL_REL: begin
                    n_scl_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_S_POLL;
                    n_wait      = '0;
                end
                PH_S_POLL: begin
                    n_wait = wait_after;
                    if (poll_high) begin
                        n_phase = PH_S_SDA_LOW;
                    end else if (poll_to) begin
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
                PH_S_SDA_LOW: begin
                    if (n_active_cmd == CMD_START && !sda_h) begin
                        done    = 1'b1;
                        status  = ST_BUSY;
                        n_phase = PH_IDLE;
                    end else begin
                        n_sda_drive = 1'b1;
                        n_delay     = delay_sat;
                        n_phase     = PH_S_SCL_LOW;
                    end
                end
                PH_S_SCL_LOW: begin
                    n_scl_drive = 1'b1;
                    n_delay     = delay_sat;
                    n_phase     = PH_FINISH;
                end
                PH_P_SDA_LOW: begin
                    n_sda_drive = 1'b1;
                    n_delay     = delay_sat;
                    n_phase     = PH_P_SCL_REL;
                end
                PH_P_SCL_REL: begin
                    n_scl_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_P_POLL;
                    n_wait      = '0;
                end
                PH_P_POLL: begin
                    n_wait = wait_after;
                    if (poll_high) begin
                        n_phase = PH_P_SDA_REL;
                    end else if (poll_to) begin
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
                PH_P_SDA_REL: begin
                    n_sda_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_FINISH;
                end
                PH_B_SDA: begin
                    if (n_bit_count < DATA_BITS) begin
                        n_sda_drive = (n_active_cmd == CMD_WRITE)
                                      && ((n_shift & MSB_MASK) == '0);
                    end else begin
                        n_sda_drive = (n_active_cmd == CMD_READ) && n_ack;
                    end
                    n_delay = delay_sat;
                    n_phase = PH_B_SCL_REL;
                end
                PH_B_SCL_REL: begin
                    n_scl_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_B_POLL;
                    n_wait      = '0;
                end
                PH_B_POLL: begin
                    n_wait = wait_after;
                    if (poll_high) begin
                        n_phase = PH_B_SCL_LOW;
                    end else if (poll_to) begin
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
                PH_B_SCL_LOW: begin
                    if (n_bit_count < DATA_BITS) begin
                        n_shift = {n_shift[6:0], (n_active_cmd == CMD_READ) && sda_h};
                    end else if (n_active_cmd == CMD_WRITE) begin
                        n_ack = !sim && sda_h;
                    end
                    n_bit_count = n_bit_count + 1'b1;
                    n_scl_drive = 1'b1;
                    n_delay     = delay_sat;
                    n_phase     = (n_bit_count > DATA_BITS) ? PH_FINISH : PH_B_SDA;
                end
                PH_R_SDA_REL: begin
                    n_sda_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_R_CHECK;
                    n_pulse     = '0;
                end
                PH_R_CHECK: begin
                    if (n_pulse >= PulseLimit || sda_h) begin
                        n_phase = PH_P_SDA_LOW;
                    end else begin
                        n_scl_drive = 1'b1;
                        n_delay     = delay_sat;
                        n_phase     = PH_R_SCL_REL;
                    end
                end
                PH_R_SCL_REL: begin
                    n_scl_drive = 1'b0;
                    n_delay     = delay_sat;
                    n_phase     = PH_R_POLL;
                    n_wait      = '0;
                end
                PH_R_POLL: begin
                    n_wait = wait_after;
                    if (poll_high) begin
                        n_pulse = n_pulse + 1'b1;
                        n_phase = PH_R_CHECK;
                    end else if (poll_to) begin
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
                PH_FINISH: begin
                    done = 1'b1;
                    case (n_active_cmd)
                        CMD_RECOVER: status = (scl_h && sda_h) ? ST_OK : ST_BUSY;
                        CMD_WRITE:   status = n_ack ? ST_NACK : ST_OK;
                        CMD_READ:    n_last_read = n_shift;
                        default:     status = ST_OK;
                    endcase
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_active_cmd <= CMD_NONE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_ack        <= 1'b0;
            r_delay      <= '0;
            r_wait       <= '0;
            r_pulse      <= '0;
            r_scl_drive  <= 1'b0;
            r_sda_drive  <= 1'b0;
            r_last_read  <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_active_cmd <= n_active_cmd;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_ack        <= n_ack;
            r_delay      <= n_delay;
            r_wait       <= n_wait;
            r_pulse      <= n_pulse;
            r_scl_drive  <= n_scl_drive;
            r_sda_drive  <= n_sda_drive;
            r_last_read  <= n_last_read;
        end
    end

    always_comb begin
        o_word              = '0;
        o_word.scl_pull_low = n_scl_drive;
        o_word.sda_pull_low = n_sda_drive;
        o_word.engine_busy  = (n_phase != PH_IDLE);
        o_word.command_done = done;
        o_word.status       = status;
        o_word.read_data    = n_last_read;
    end

endmodule

FILE: rtl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// An accepted tick word is held in the input register; its result word is registered in the result register.
// Throughput: one tick word per cycle while the output is not stalled; the sequencer update is a single pass.
// A stalled output holds the result register and backs up the input register.
// Reset (synchronous, active low) clears the sequencer, drops both valids and
// loads the register defaults.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit #(
    parameter int COUNT_WIDTH     = 16,
    parameter int RECOVERY_PULSES = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [i2cbe_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [i2cbe_pkg::CfgWidth-1:0]     i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // command[2:0], data_byte[10:3], reply_ack[11], scl_level[12], sda_level[13]
    input  logic [i2cbe_pkg::WordWidth-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // scl_pull_low[0], sda_pull_low[1], engine_busy[2], command_done[3],
    // status[5:4], read_data[13:6]
    output logic [i2cbe_pkg::WordWidth-1:0]    m_axis_tdata
);
    import i2cbe_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word step_word;
    logic      advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_delay       <= BIT_DELAY_RESET;
            r_cfg.stretch_timeout <= STRETCH_TIMEOUT_RESET;
            r_cfg.simulate_lines  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BIT_DELAY:       r_cfg.bit_delay       <= i_cfg_wdata;
                REG_STRETCH_TIMEOUT: r_cfg.stretch_timeout <= i_cfg_wdata;
                REG_SIMULATE_LINES:  r_cfg.simulate_lines  <= i_cfg_wdata[0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_word <= t_in_word'(s_axis_tdata);
        end
    end

    i2cbe_step #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .RECOVERY_PULSES (RECOVERY_PULSES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cfg   (r_cfg),
        .i_word  (r_in_word),
        .o_word  (step_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= step_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

FILE: rtl/i2cbe_checker.sv
// ----------------------------------------------------------------------------
// i2cbe_checker
// Port-level checks of the bit engine result stream, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbe_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [i2cbe_pkg::WordWidth-1:0] m_axis_tdata
);
    import i2cbe_pkg::*;

    t_out_word word;
    assign word = t_out_word'(m_axis_tdata);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !word.command_done |-> word.status == ST_OK)
        else $error("status set without command done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && word.command_done |-> !word.engine_busy)
        else $error("engine busy on the done word");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_i2cbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
